// ===== sv/blpd_pkg.sv =====
// ----------------------------------------------------------------------------
// blpd_pkg: shared types and constants of the breathing LED PWM driver
// Field widths, register and mode codes, the quarter-wave sine table and
// the small arithmetic helpers called by the modules.
// ----------------------------------------------------------------------------
package blpd_pkg;

  localparam int unsigned PHASE_STEPS_DEF = 1024;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned ANGLE_W    = 14;
  localparam int unsigned QTR_W      = 12;
  localparam int unsigned SINE_W     = 17;
  localparam int unsigned DIFF_W     = 13;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // restoring divider: steps per pipeline stage, stages for the modulo
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned MOD_STAGES = TIME_W / DIV_STEPS;

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RED    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLUE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_YELLOW = 3'd4;

  localparam logic [PCT_W-1:0]    PCT_MAX      = 7'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd2000;
  localparam logic [DUTY_W-1:0]   DUTY_FULL    = 8'd255;
  localparam logic [DUTY_W-1:0]   FLOOR_RST    = 8'd25;
  localparam logic [DUTY_W-1:0]   SPAN_RST     = 8'd230;
  localparam logic [SINE_W-1:0]   SINE_ONE     = 17'h10000;
  localparam logic [ANGLE_W-1:0]  ANGLE_QTR    = 14'd4096;

  // peak = pct * 255 / 100 by reciprocal, floor = peak / 10 by reciprocal
  localparam logic [15:0] PEAK_RECIP  = 16'd41944;
  localparam int unsigned PEAK_SHIFT  = 22;
  localparam logic [15:0] TENTH_RECIP = 16'd205;
  localparam int unsigned TENTH_SHIFT = 11;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [MODE_W-1:0]   mode;
    logic [DUTY_W-1:0]   floor_duty;
    logic [DUTY_W-1:0]   span;
  } cfg_t;

  // partial remainder and the shifting dividend / quotient word
  typedef struct packed {
    logic [PERIOD_W-1:0] rem;
    logic [TIME_W-1:0]   quo;
  } divw_t;

  function automatic divw_t div_step(divw_t cur, logic [PERIOD_W-1:0] divisor);
    logic [PERIOD_W:0] trial;
    divw_t             nxt;
    trial   = {cur.rem, cur.quo[TIME_W-1]};
    nxt.quo = {cur.quo[TIME_W-2:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      nxt.rem    = PERIOD_W'(trial - {1'b0, divisor});
      nxt.quo[0] = 1'b1;
    end else begin
      nxt.rem = trial[PERIOD_W-1:0];
    end
    return nxt;
  endfunction

  // sin(k*pi/32) in Q1.16, k = 0..16
  function automatic logic [SINE_W-1:0] sine_q16(logic [4:0] k);
    logic [SINE_W-1:0] s;
    unique case (k)
      5'd0:    s = 17'd0;
      5'd1:    s = 17'd6424;
      5'd2:    s = 17'd12785;
      5'd3:    s = 17'd19024;
      5'd4:    s = 17'd25080;
      5'd5:    s = 17'd30893;
      5'd6:    s = 17'd36410;
      5'd7:    s = 17'd41576;
      5'd8:    s = 17'd46341;
      5'd9:    s = 17'd50660;
      5'd10:   s = 17'd54491;
      5'd11:   s = 17'd57798;
      5'd12:   s = 17'd60547;
      5'd13:   s = 17'd62714;
      5'd14:   s = 17'd64277;
      5'd15:   s = 17'd65220;
      5'd16:   s = 17'd65536;
      default: s = 17'd0;
    endcase
    return s;
  endfunction

  function automatic logic [DUTY_W-1:0] pct_to_peak(logic [PCT_W-1:0] pct);
    logic [14:0] scaled;
    logic [30:0] prod;
    scaled = {pct, 8'd0} - 15'(pct);
    prod   = 31'(scaled) * 31'(PEAK_RECIP);
    return prod[PEAK_SHIFT +: DUTY_W];
  endfunction

  function automatic logic [DUTY_W-1:0] peak_to_floor(logic [DUTY_W-1:0] peak);
    logic [15:0] prod;
    prod = 16'(peak) * TENTH_RECIP;
    return DUTY_W'(prod >> TENTH_SHIFT);
  endfunction

endpackage

// ===== sv/breathing_led_pwm_driver_top.sv =====
// ----------------------------------------------------------------------------
// breathing_led_pwm_driver_top: sine-breathing RGB PWM compare generator
// Turns millisecond ticks into three active-low 8-bit PWM compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_now_ms): one transfer per update
//   tick carrying the free-running millisecond time.
//   Result channel (out_valid / out_stall / out_*_compare): exactly one
//   transfer per input transfer, in order; 255 means LED off.
//   Config port (cfg_we / cfg_idx / cfg_wdata): index 0 brightness percent
//   (low 7 bits, above 100 saturates), 1 breathing period in ms (0 blanks
//   all channels), 2 colour mode (low 3 bits: 0 off, 1 red, 2 green, 3 blue,
//   4 yellow, others off). Write only while no transfer is in flight.
// Pipeline: the 32-bit modulo divider (8 stages of 4 steps), the step-count
//   scaling stage, the phase divider, the angle scaling stage and five
//   shading stages.
// Throughput: one tick per cycle unless in_stall is raised; every stage
//   hands its valid bit on with its data.
// Reset clears all valid bits and loads brightness 100, period 2000, mode
//   off. A stall on the result channel holds the output register; upstream
//   stages keep filling bubbles, and in_stall rises only once every stage
//   holds a tick.
// ----------------------------------------------------------------------------
module breathing_led_pwm_driver_top #(
  parameter int unsigned PHASE_STEPS = blpd_pkg::PHASE_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [blpd_pkg::TIME_W-1:0]      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [blpd_pkg::DUTY_W-1:0]      out_red_compare,
  output logic [blpd_pkg::DUTY_W-1:0]      out_green_compare,
  output logic [blpd_pkg::DUTY_W-1:0]      out_blue_compare,
  input  logic                             cfg_we,
  input  logic [blpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [blpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  blpd_pkg::cfg_t                 cfg;
  logic                           ang_valid;
  logic                           ang_stall;
  logic [blpd_pkg::ANGLE_W-1:0]   ang;

  // config registers and derived floor / span
  blpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // time -> phase angle (dividers and scaling)
  blpd_phase #(.PHASE_STEPS(PHASE_STEPS)) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .period    (cfg.period),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_now_ms (in_now_ms),
    .out_valid (ang_valid),
    .out_stall (ang_stall),
    .out_angle (ang)
  );

  // angle -> cosine level -> duty -> channel compares
  blpd_shade u_shade (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (ang_valid),
    .in_stall          (ang_stall),
    .in_angle          (ang),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red_compare   (out_red_compare),
    .out_green_compare (out_green_compare),
    .out_blue_compare  (out_blue_compare)
  );

  // input back-pressure only when the whole pipe is full and the output blocked
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && ang_valid && ang_stall))
    else $error("input stalled while the pipeline still had room");

  // blue never lights together with red or green
  a_blue_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_blue_compare == blpd_pkg::DUTY_FULL) ||
                   ((out_red_compare == blpd_pkg::DUTY_FULL) &&
                    (out_green_compare == blpd_pkg::DUTY_FULL))))
    else $error("blue lit together with red or green");

  // red and green carry the same duty when both are lit
  a_yellow_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_red_compare != blpd_pkg::DUTY_FULL) &&
     (out_green_compare != blpd_pkg::DUTY_FULL)) |-> (out_red_compare == out_green_compare))
    else $error("red and green duty differ");

  // reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !ang_valid))
    else $error("valid bits survived reset");

endmodule

// ===== sv/blpd_cfg.sv =====
// ----------------------------------------------------------------------------
// blpd_cfg: configuration registers
// Holds brightness, period and colour mode, and derives the duty floor and
// span from the brightness over two register stages.
// ----------------------------------------------------------------------------
module blpd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [blpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [blpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output blpd_pkg::cfg_t                   cfg
);

  logic [blpd_pkg::PCT_W-1:0]    pct_r, pct_nxt;
  logic [blpd_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [blpd_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [blpd_pkg::DUTY_W-1:0]   peak_r, peak_nxt;
  logic [blpd_pkg::DUTY_W-1:0]   floor_r, floor_nxt;
  logic [blpd_pkg::DUTY_W-1:0]   span_r, span_nxt;

  always_comb begin
    pct_nxt    = pct_r;
    period_nxt = period_r;
    mode_nxt   = mode_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        blpd_pkg::REG_BRIGHTNESS: begin
          if (cfg_wdata[blpd_pkg::PCT_W-1:0] > blpd_pkg::PCT_MAX) begin
            pct_nxt = blpd_pkg::PCT_MAX;
          end else begin
            pct_nxt = cfg_wdata[blpd_pkg::PCT_W-1:0];
          end
        end
        blpd_pkg::REG_PERIOD: period_nxt = cfg_wdata[blpd_pkg::PERIOD_W-1:0];
        blpd_pkg::REG_MODE:   mode_nxt   = cfg_wdata[blpd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // derive peak, then floor and span from the registered peak
  always_comb begin
    peak_nxt  = blpd_pkg::pct_to_peak(pct_r);
    floor_nxt = blpd_pkg::peak_to_floor(peak_r);
    span_nxt  = peak_r - floor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r    <= blpd_pkg::PCT_MAX;
      period_r <= blpd_pkg::PERIOD_RST;
      mode_r   <= blpd_pkg::MODE_OFF;
      peak_r   <= blpd_pkg::DUTY_FULL;
      floor_r  <= blpd_pkg::FLOOR_RST;
      span_r   <= blpd_pkg::SPAN_RST;
    end else begin
      pct_r    <= pct_nxt;
      period_r <= period_nxt;
      mode_r   <= mode_nxt;
      peak_r   <= peak_nxt;
      floor_r  <= floor_nxt;
      span_r   <= span_nxt;
    end
  end

  assign cfg.period     = period_r;
  assign cfg.mode       = mode_r;
  assign cfg.floor_duty = floor_r;
  assign cfg.span       = span_r;

endmodule

// ===== sv/blpd_div_stage.sv =====
// ----------------------------------------------------------------------------
// blpd_div_stage: one register stage of the restoring divider
// Runs STEPS shift-and-subtract steps on the word and registers the result.
// ----------------------------------------------------------------------------
module blpd_div_stage #(
  parameter int unsigned STEPS = blpd_pkg::DIV_STEPS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [blpd_pkg::PERIOD_W-1:0]   divisor,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  blpd_pkg::divw_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output blpd_pkg::divw_t                 out_data
);

  logic            valid_r;
  blpd_pkg::divw_t data_r, data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < STEPS; i++) begin
      data_nxt = blpd_pkg::div_step(data_nxt, divisor);
    end
  end

  // hold only while full and blocked downstream
  assign in_stall = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/blpd_phase.sv =====
// ----------------------------------------------------------------------------
// blpd_phase: time to breathing angle
// now mod period over a pipelined divider, scale by the phase step count,
// a second divide for the phase index, then scale the index to the
// 14-bit circle angle.
// ----------------------------------------------------------------------------
module blpd_phase #(
  parameter int unsigned PHASE_STEPS = blpd_pkg::PHASE_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [blpd_pkg::PERIOD_W-1:0]   period,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [blpd_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [blpd_pkg::ANGLE_W-1:0]    out_angle
);

  localparam int unsigned PW        = $clog2(PHASE_STEPS);
  localparam int unsigned PH_STAGES = (PW + blpd_pkg::DIV_STEPS - 1) / blpd_pkg::DIV_STEPS;
  localparam int unsigned PH_LAST   = PW - (PH_STAGES - 1) * blpd_pkg::DIV_STEPS;
  localparam int unsigned PROD_W    = blpd_pkg::PERIOD_W + PW;
  localparam int unsigned ANG_K     = 2 * PW + 1;
  localparam int unsigned ANG_MW    = PW + 17;
  localparam logic [ANG_MW-1:0] ANG_M =
    ANG_MW'(((64'd1 << (ANG_K + blpd_pkg::ANGLE_W)) + 64'(PHASE_STEPS) - 64'd1)
            / 64'(PHASE_STEPS));

  logic            mod_v [blpd_pkg::MOD_STAGES+1];
  logic            mod_s [blpd_pkg::MOD_STAGES+1];
  blpd_pkg::divw_t mod_d [blpd_pkg::MOD_STAGES+1];

  logic            ph_v [PH_STAGES+1];
  logic            ph_s [PH_STAGES+1];
  blpd_pkg::divw_t ph_d [PH_STAGES+1];

  logic              scl_v_r;
  logic              scl_hold;
  blpd_pkg::divw_t   scl_r, scl_nxt;
  logic [PROD_W-1:0] scl_prod;

  logic                           ang_v_r;
  logic                           ang_hold;
  logic [blpd_pkg::ANGLE_W-1:0]   ang_r, ang_nxt;
  logic [PW+ANG_MW-1:0]           ang_prod;

  // modulo: dividend enters the quotient word, remainder starts at zero
  assign mod_v[0]     = in_valid;
  assign in_stall     = mod_s[0];
  assign mod_d[0].rem = '0;
  assign mod_d[0].quo = in_now_ms;

  for (genvar g = 0; g < blpd_pkg::MOD_STAGES; g++) begin : g_mod
    blpd_div_stage #(.STEPS(blpd_pkg::DIV_STEPS)) u_mod (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (period),
      .in_valid  (mod_v[g]),
      .in_stall  (mod_s[g]),
      .in_data   (mod_d[g]),
      .out_valid (mod_v[g+1]),
      .out_stall (mod_s[g+1]),
      .out_data  (mod_d[g+1])
    );
  end

  // scale remainder by the step count; the upper part is already below period
  always_comb begin
    scl_prod    = PROD_W'(mod_d[blpd_pkg::MOD_STAGES].rem) * PROD_W'(PHASE_STEPS);
    scl_nxt.rem = scl_prod[PW +: blpd_pkg::PERIOD_W];
    scl_nxt.quo = {scl_prod[PW-1:0], (blpd_pkg::TIME_W-PW)'(0)};
  end

  assign scl_hold                   = scl_v_r && ph_s[0];
  assign mod_s[blpd_pkg::MOD_STAGES] = scl_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_v_r <= 1'b0;
    end else if (!scl_hold) begin
      scl_v_r <= mod_v[blpd_pkg::MOD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (!scl_hold) begin
      scl_r <= scl_nxt;
    end
  end

  assign ph_v[0] = scl_v_r;
  assign ph_d[0] = scl_r;

  for (genvar g = 0; g < PH_STAGES; g++) begin : g_ph
    localparam int unsigned STG_STEPS = (g == PH_STAGES - 1) ? PH_LAST : blpd_pkg::DIV_STEPS;
    blpd_div_stage #(.STEPS(STG_STEPS)) u_ph (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (period),
      .in_valid  (ph_v[g]),
      .in_stall  (ph_s[g]),
      .in_data   (ph_d[g]),
      .out_valid (ph_v[g+1]),
      .out_stall (ph_s[g+1]),
      .out_data  (ph_d[g+1])
    );
  end

  // angle = index * 16384 / steps, by reciprocal multiply
  always_comb begin
    ang_prod = (PW+ANG_MW)'(ph_d[PH_STAGES].quo[PW-1:0]) * (PW+ANG_MW)'(ANG_M);
    ang_nxt  = ang_prod[ANG_K +: blpd_pkg::ANGLE_W];
  end

  assign ang_hold        = ang_v_r && out_stall;
  assign ph_s[PH_STAGES] = ang_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_v_r <= 1'b0;
    end else if (!ang_hold) begin
      ang_v_r <= ph_v[PH_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (!ang_hold) begin
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = ang_v_r;
  assign out_angle = ang_r;

endmodule

// ===== sv/blpd_shade.sv =====
// ----------------------------------------------------------------------------
// blpd_shade: angle to PWM compare values
// Cosine by folded quarter-wave table with interpolation, breathing level,
// duty between floor and peak, and per-channel active-low compares.
// ----------------------------------------------------------------------------
module blpd_shade (
  input  logic                           clk,
  input  logic                           rst_n,
  input  blpd_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [blpd_pkg::ANGLE_W-1:0]   in_angle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [blpd_pkg::DUTY_W-1:0]    out_red_compare,
  output logic [blpd_pkg::DUTY_W-1:0]    out_green_compare,
  output logic [blpd_pkg::DUTY_W-1:0]    out_blue_compare
);

  // stage 1: fold and table fetch
  logic                          s1_v_r, s1_hold;
  logic [blpd_pkg::ANGLE_W-1:0]  s1_w;
  logic [blpd_pkg::QTR_W:0]      s1_x;
  logic [blpd_pkg::SINE_W-1:0]   s1_lo, s1_hi;
  logic [blpd_pkg::SINE_W-1:0]   s1_lo_r;
  logic [blpd_pkg::DIFF_W-1:0]   s1_diff_r;
  logic [blpd_pkg::FRAC_W-1:0]   s1_frac_r;
  logic                          s1_full_r, s1_neg_r;

  // stage 2: interpolated sine
  logic                          s2_v_r, s2_hold;
  logic [blpd_pkg::SINE_W-1:0]   s2_sine_nxt, s2_sine_r;
  logic                          s2_neg_r;
  logic [blpd_pkg::DIFF_W+blpd_pkg::FRAC_W-1:0] s2_prod;

  // stage 3: breathing level
  logic                          s3_v_r, s3_hold;
  logic [blpd_pkg::SINE_W:0]     s3_sum;
  logic [blpd_pkg::SINE_W-1:0]   s3_level_r;

  // stage 4: duty
  logic                          s4_v_r, s4_hold;
  logic [blpd_pkg::SINE_W+blpd_pkg::DUTY_W-1:0] s4_prod;
  logic [blpd_pkg::DUTY_W:0]     s4_sum;
  logic [blpd_pkg::DUTY_W-1:0]   s4_duty_nxt, s4_duty_r;

  // stage 5: output register
  logic                          s5_v_r, s5_hold;
  logic                          s5_en, s5_red_on, s5_green_on, s5_blue_on;
  logic [blpd_pkg::DUTY_W-1:0]   red_r, green_r, blue_r;
  logic [blpd_pkg::DUTY_W-1:0]   red_nxt, green_nxt, blue_nxt;

  assign s5_hold  = s5_v_r && out_stall;
  assign s4_hold  = s4_v_r && s5_hold;
  assign s3_hold  = s3_v_r && s4_hold;
  assign s2_hold  = s2_v_r && s3_hold;
  assign s1_hold  = s1_v_r && s2_hold;
  assign in_stall = s1_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (!s1_hold) s1_v_r <= in_valid;
      if (!s2_hold) s2_v_r <= s1_v_r;
      if (!s3_hold) s3_v_r <= s2_v_r;
      if (!s4_hold) s4_v_r <= s3_v_r;
      if (!s5_hold) s5_v_r <= s4_v_r;
    end
  end

  // cosine is the sine a quarter turn ahead; mirror odd quadrants
  always_comb begin
    s1_w = blpd_pkg::ANGLE_W'(in_angle + blpd_pkg::ANGLE_QTR);
    if (s1_w[blpd_pkg::QTR_W]) begin
      s1_x = (blpd_pkg::QTR_W+1)'(blpd_pkg::ANGLE_QTR) - {1'b0, s1_w[blpd_pkg::QTR_W-1:0]};
    end else begin
      s1_x = {1'b0, s1_w[blpd_pkg::QTR_W-1:0]};
    end
    s1_lo = blpd_pkg::sine_q16({1'b0, s1_x[blpd_pkg::QTR_W-1:blpd_pkg::FRAC_W]});
    s1_hi = blpd_pkg::sine_q16(5'({1'b0, s1_x[blpd_pkg::QTR_W-1:blpd_pkg::FRAC_W]}) + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!s1_hold) begin
      s1_lo_r   <= s1_lo;
      s1_diff_r <= blpd_pkg::DIFF_W'(s1_hi - s1_lo);
      s1_frac_r <= s1_x[blpd_pkg::FRAC_W-1:0];
      s1_full_r <= s1_x[blpd_pkg::QTR_W];
      s1_neg_r  <= s1_w[blpd_pkg::ANGLE_W-1];
    end
  end

  always_comb begin
    s2_prod = (blpd_pkg::DIFF_W+blpd_pkg::FRAC_W)'(s1_diff_r) *
              (blpd_pkg::DIFF_W+blpd_pkg::FRAC_W)'(s1_frac_r);
    if (s1_full_r) begin
      s2_sine_nxt = blpd_pkg::SINE_ONE;
    end else begin
      s2_sine_nxt = s1_lo_r + blpd_pkg::SINE_W'(s2_prod >> blpd_pkg::FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!s2_hold) begin
      s2_sine_r <= s2_sine_nxt;
      s2_neg_r  <= s1_neg_r;
    end
  end

  // level = (1 - cos) / 2
  always_comb begin
    if (s2_neg_r) begin
      s3_sum = {1'b0, blpd_pkg::SINE_ONE} + {1'b0, s2_sine_r};
    end else begin
      s3_sum = {1'b0, blpd_pkg::SINE_ONE} - {1'b0, s2_sine_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!s3_hold) begin
      s3_level_r <= s3_sum[blpd_pkg::SINE_W:1];
    end
  end

  always_comb begin
    s4_prod = (blpd_pkg::SINE_W+blpd_pkg::DUTY_W)'(s3_level_r) *
              (blpd_pkg::SINE_W+blpd_pkg::DUTY_W)'(cfg.span);
    s4_sum  = {1'b0, cfg.floor_duty} + {1'b0, s4_prod[16 +: blpd_pkg::DUTY_W]};
    if (s4_sum[blpd_pkg::DUTY_W]) begin
      s4_duty_nxt = blpd_pkg::DUTY_FULL;
    end else begin
      s4_duty_nxt = s4_sum[blpd_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!s4_hold) begin
      s4_duty_r <= s4_duty_nxt;
    end
  end

  // pick channels; anything not lit shows full compare (LED off)
  always_comb begin
    s5_en       = (cfg.period != '0) &&
                  ((cfg.mode == blpd_pkg::MODE_RED) || (cfg.mode == blpd_pkg::MODE_GREEN) ||
                   (cfg.mode == blpd_pkg::MODE_BLUE) || (cfg.mode == blpd_pkg::MODE_YELLOW));
    s5_red_on   = s5_en && ((cfg.mode == blpd_pkg::MODE_RED) ||
                            (cfg.mode == blpd_pkg::MODE_YELLOW));
    s5_green_on = s5_en && ((cfg.mode == blpd_pkg::MODE_GREEN) ||
                            (cfg.mode == blpd_pkg::MODE_YELLOW));
    s5_blue_on  = s5_en && (cfg.mode == blpd_pkg::MODE_BLUE);
    red_nxt     = s5_red_on   ? blpd_pkg::DUTY_FULL - s4_duty_r : blpd_pkg::DUTY_FULL;
    green_nxt   = s5_green_on ? blpd_pkg::DUTY_FULL - s4_duty_r : blpd_pkg::DUTY_FULL;
    blue_nxt    = s5_blue_on  ? blpd_pkg::DUTY_FULL - s4_duty_r : blpd_pkg::DUTY_FULL;
  end

  always_ff @(posedge clk) begin
    if (!s5_hold) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid         = s5_v_r;
  assign out_red_compare   = red_r;
  assign out_green_compare = green_r;
  assign out_blue_compare  = blue_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the breathing LED PWM driver
// Streams millisecond ticks through the driver under random valid/stall
// gaps, predicts the red, green and blue compare values of every tick from
// a shadow copy of the registers, and checks each result transfer in order.
// Registers are rewritten between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb;
  import blpd_pkg::*;

  // Pipeline depth at the default phase resolution plus some margin.
  localparam int unsigned PIPE_LAT     = 18;
  localparam int unsigned DRAIN_CYCLES = PIPE_LAT + 8;
  localparam int unsigned STEPS        = PHASE_STEPS_DEF;
  localparam int unsigned RAND_PHASES  = 26;
  localparam int unsigned PHASE_TICKS  = 52;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;

  // The register port has room for a fourth index that maps to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } rgb_compare_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DUTY_W-1:0]     out_red_compare;
  logic [DUTY_W-1:0]     out_green_compare;
  logic [DUTY_W-1:0]     out_blue_compare;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow registers, loaded with the reset values of the block.
  logic [PCT_W-1:0]      shadow_pct = PCT_MAX;
  logic [PERIOD_W-1:0]   shadow_period = PERIOD_RST;
  logic [MODE_W-1:0]     shadow_mode = MODE_OFF;

  logic [TIME_W-1:0]     tick_q[$];     // ticks waiting to be offered
  rgb_compare_t          compare_q[$];  // compares owed by the block, oldest first

  int unsigned           mismatch_count = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  int unsigned           send_gap = 0;
  int unsigned           recv_gap = 0;
  int unsigned           hold_req_cnt = 0;
  int unsigned           hold_seen_cnt = 0;
  int unsigned           hold_left = 0;

  breathing_led_pwm_driver_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red_compare   (out_red_compare),
    .out_green_compare (out_green_compare),
    .out_blue_compare  (out_blue_compare),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a transfer never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // sin(k*pi/32) in Q1.16
  function automatic int sine_point(int unsigned k);
    case (k)
      0:  return 0;
      1:  return 6424;
      2:  return 12785;
      3:  return 19024;
      4:  return 25080;
      5:  return 30893;
      6:  return 36410;
      7:  return 41576;
      8:  return 46341;
      9:  return 50660;
      10: return 54491;
      11: return 57798;
      12: return 60547;
      13: return 62714;
      14: return 64277;
      15: return 65220;
      default: return 65536;
    endcase
  endfunction

  // Interpolated sine over a quarter wave, x in [0, 4096].
  function automatic int quarter_wave(int unsigned x);
    int unsigned seg;
    int          frac;
    int          lo;
    int          hi;
    if (x >= 4096) return sine_point(16);
    seg  = x >> 8;
    frac = int'(x & 255);
    lo   = sine_point(seg);
    hi   = sine_point(seg + 1);
    return lo + ((hi - lo) * frac) / 256;
  endfunction

  // Cosine over a 16384-unit circle, unfolded by quadrant.
  function automatic int circle_cosine(int unsigned angle);
    int unsigned w;
    int unsigned r;
    w = (angle + 4096) & 16383;
    r = w & 4095;
    case (w >> 12)
      0:       return quarter_wave(r);
      1:       return quarter_wave(4096 - r);
      2:       return -quarter_wave(r);
      default: return -quarter_wave(4096 - r);
    endcase
  endfunction

  // Compare values for one tick under the shadow register settings.
  function automatic rgb_compare_t breathe_compares(logic [TIME_W-1:0] now);
    rgb_compare_t      res;
    longint unsigned   rem_ms;
    longint unsigned   phase_idx;
    longint unsigned   angle;
    int                cosv;
    longint unsigned   level;
    longint unsigned   peak;
    longint unsigned   floor_duty;
    longint unsigned   duty;
    logic              r_on;
    logic              g_on;
    logic              b_on;
    r_on = 1'b0;
    g_on = 1'b0;
    b_on = 1'b0;
    duty = 0;
    case (shadow_mode)
      MODE_RED:    r_on = 1'b1;
      MODE_GREEN:  g_on = 1'b1;
      MODE_BLUE:   b_on = 1'b1;
      MODE_YELLOW: begin
        r_on = 1'b1;
        g_on = 1'b1;
      end
      default: ;
    endcase
    // A zero period blanks every channel, whatever the mode.
    if (shadow_period == 0) begin
      r_on = 1'b0;
      g_on = 1'b0;
      b_on = 1'b0;
    end else begin
      rem_ms     = longint'(now) % longint'(shadow_period);
      phase_idx  = (rem_ms * STEPS) / longint'(shadow_period);
      angle      = ((phase_idx * 16384) / STEPS) & 16383;
      cosv       = circle_cosine(int'(angle));
      level      = longint'(65536 - cosv) >> 1;
      peak       = (longint'(shadow_pct) * 255) / 100;
      floor_duty = peak / 10;
      duty       = floor_duty + ((level * (peak - floor_duty)) >> 16);
      if (duty > 255) duty = 255;
    end
    res.red   = DUTY_FULL - (r_on ? DUTY_W'(duty) : '0);
    res.green = DUTY_FULL - (g_on ? DUTY_W'(duty) : '0);
    res.blue  = DUTY_FULL - (b_on ? DUTY_W'(duty) : '0);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued ticks, with random gaps between transfers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_now_ms <= '0;
      send_gap  = 0;
    end else begin
      // Record what the block owes for the tick it just took.
      if (in_valid && !in_stall) begin
        compare_q.push_back(breathe_compares(in_now_ms));
        void'(tick_q.pop_front());
      end
      // A stalled tick stays on the bus untouched.
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid  <= 1'b1;
          in_now_ms <= tick_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every result transfer and drive the result stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_compare_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (compare_q.size() == 0) begin
          $error("result transfer with nothing expected: red %0d green %0d blue %0d",
                 out_red_compare, out_green_compare, out_blue_compare);
          mismatch_count++;
        end else begin
          want = compare_q.pop_front();
          if (out_red_compare !== want.red) begin
            $error("red_compare: expected %0d, actual %0d", want.red, out_red_compare);
            mismatch_count++;
          end
          if (out_green_compare !== want.green) begin
            $error("green_compare: expected %0d, actual %0d", want.green, out_green_compare);
            mismatch_count++;
          end
          if (out_blue_compare !== want.blue) begin
            $error("blue_compare: expected %0d, actual %0d", want.blue, out_blue_compare);
            mismatch_count++;
          end
        end
      end
      // Start a long hold-off when asked, so the pipeline backs up to the input.
      if (hold_req_cnt != hold_seen_cnt) begin
        hold_seen_cnt++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register and mirror the write into the shadow copy.
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_BRIGHTNESS: shadow_pct = (data[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : data[PCT_W-1:0];
      REG_PERIOD:     shadow_period = data;
      REG_MODE:       shadow_mode = data[MODE_W-1:0];
      default: ;  // unused index: the block drops the write
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every tick has been taken and every result has come back.
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || compare_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly a running clock with small steps, as a real tick source gives;
  // the rest jumps at random or lands on period boundaries and time extremes.
  task automatic queue_ticks(int unsigned count);
    logic [TIME_W-1:0] t;
    int unsigned       span;
    int unsigned       pick;
    t    = $urandom;
    span = (shadow_period > 32) ? shadow_period / 32 : 1;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        t = t + $urandom_range(1, span);
      end else if (pick < 9) begin
        t = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: t = '0;
          1: t = '1;
          2: t = (shadow_period != 0) ? t - (t % shadow_period) : t;
          default: t = (shadow_period != 0) ?
                       t - (t % shadow_period) + shadow_period - 1 : t + 1;
        endcase
      end
      tick_q.push_back(t);
    end
  endtask

  // New register settings; on edge phases lean hard on the extremes.
  task automatic pick_settings(bit edge_case);
    logic [CFG_DATA_W-1:0] pct_data;
    logic [CFG_DATA_W-1:0] period_data;
    logic [CFG_DATA_W-1:0] mode_data;
    if (edge_case) begin
      case ($urandom_range(0, 3))
        0:       pct_data = 16'd0;
        1:       pct_data = 16'(PCT_MAX);
        2:       pct_data = 16'd127;
        default: pct_data = 16'hFFFF;
      endcase
      case ($urandom_range(0, 7))
        0:       period_data = 16'd0;
        1, 2:    period_data = 16'd1;
        3:       period_data = 16'd2;
        default: period_data = 16'hFFFF;
      endcase
      mode_data = {13'($urandom), 3'($urandom_range(0, 7))};
    end else begin
      pct_data    = 16'($urandom);
      period_data = $urandom_range(0, 1) ? 16'($urandom_range(3, 4000))
                                         : 16'($urandom_range(3, 65535));
      mode_data   = {13'($urandom), 3'($urandom_range(1, 4))};
    end
    reg_write(REG_PERIOD, period_data);
    reg_write(REG_BRIGHTNESS, pct_data);
    reg_write(REG_MODE, mode_data);
    if ($urandom_range(0, 3) == 0) reg_write(REG_UNUSED, 16'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold reset at the start, then release it for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 10;

    // Reset settings: mode off, so every channel stays dark.
    tick_q.push_back(32'd0);
    tick_q.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Red at full brightness: floor at phase zero, peak at half period.
    reg_write(REG_MODE, 16'(MODE_RED));
    tick_q.push_back(32'd0);
    tick_q.push_back(32'd500);
    tick_q.push_back(32'd1000);
    tick_q.push_back(32'd1500);
    tick_q.push_back(32'd1999);
    tick_q.push_back(32'd2000);
    tick_q.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Green with a brightness just over the limit: saturate to 100.
    reg_write(REG_BRIGHTNESS, 16'd101);
    reg_write(REG_MODE, 16'(MODE_GREEN));
    tick_q.push_back(32'd1000);
    tick_q.push_back(32'd250);
    wait_drained();

    // Blue at zero brightness: no duty at all.
    reg_write(REG_BRIGHTNESS, 16'd0);
    reg_write(REG_MODE, 16'(MODE_BLUE));
    tick_q.push_back(32'd1000);
    wait_drained();

    // Yellow, brightness field all ones, one-millisecond period.
    reg_write(REG_BRIGHTNESS, 16'd127);
    reg_write(REG_PERIOD, 16'd1);
    reg_write(REG_MODE, 16'(MODE_YELLOW));
    tick_q.push_back(32'd0);
    tick_q.push_back(32'd12345);
    wait_drained();

    // Longest period at half brightness.
    reg_write(REG_PERIOD, 16'hFFFF);
    reg_write(REG_BRIGHTNESS, 16'd50);
    tick_q.push_back(32'd32767);
    tick_q.push_back(32'd65534);
    tick_q.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Zero period blanks all channels.
    reg_write(REG_PERIOD, 16'd0);
    tick_q.push_back(32'd1000);
    wait_drained();

    // Mode codes past yellow behave as off.
    reg_write(REG_PERIOD, 16'd3);
    reg_write(REG_MODE, 16'd5);
    tick_q.push_back(32'd1);
    wait_drained();
    reg_write(REG_MODE, 16'd6);
    tick_q.push_back(32'd2);
    wait_drained();
    reg_write(REG_MODE, 16'hFFFF);
    tick_q.push_back(32'd2);
    wait_drained();

    // A write to the unused index must leave every register alone.
    reg_write(REG_MODE, 16'(MODE_RED));
    reg_write(REG_UNUSED, 16'hFFFF);
    tick_q.push_back(32'd1);
    tick_q.push_back(32'd2);
    wait_drained();

    // Random phases: new settings each time, gaps varied per phase.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph >= RAND_PHASES - 4 || ph % 5 == 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(3, 20);
        recv_idle_pct = $urandom_range(3, 20);
      end
      pick_settings(ph % 4 == 0);
      // Back-pressure phase: keep offering while the receiver holds off long.
      if (ph == 2) begin
        send_idle_pct = 0;
        hold_req_cnt++;
      end
      queue_ticks(PHASE_TICKS);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
